// ----- rtl/hsgs_pkg.sv -----
// package: shared constants and types of the heat stencil sweep unit
package hsgs_pkg;
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;
   localparam int CFG_W = 32;
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_SWEEP  = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_CX   = 2'd2;
   localparam logic [1:0] REG_CY   = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [31:0] cell_value;
      logic        is_fixed;
   } req_word_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        sweep_done;
      logic        saturated;
   } rsp_word_type;
endpackage

// ----- rtl/hsgs_if.sv -----
// interface: valid/ready channel carrying one word
interface hsgs_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/hsgs_term.sv -----
// module: shared multiply and round unit, coefficient times difference to Q16.16
module hsgs_term (
   input  logic               clock,
   input  logic signed [31:0] coef,
   input  logic signed [33:0] diff,
   output logic signed [49:0] term
);
   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;
   logic               neg;
   logic        [65:0] mag;
   logic        [65:0] rnd;

   assign prod_in = 66'(coef) * 66'(diff);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      neg  = prod_ff[65];
      mag  = neg ? 66'(-prod_ff) : prod_ff;
      rnd  = (mag + 66'h8000) >> 16;
      term = neg ? -50'(rnd) : 50'(rnd);
   end
endmodule

// ----- rtl/heat_stencil_grid_sweep_unit.sv -----
// top level: grid store with in-place five-point stencil sweep
// Usage: the req channel takes one word: kind 0 writes a cell (no response),
// kind 2 reads a cell (one rsp word with read_value), kind 1 runs a sweep over
// the interior cells in raster order and answers with sweep_done and saturated.
// Kind 3 and writes outside the grid in use are dropped without a response.
// Config registers (rows, cols, coef_x, coef_y) are written on csr_; the user
// must write them only while idle: the block does not enforce it. A write is
// done at the accepting edge. rsp_valid rises at the accepting edge for a read
// outside the grid; an in-grid read first passes S_RD, which registers the data.
// A sweep visits each cell with one grid memory read port: 5 memory reads,
// 2 multiplies in the shared unit and 1 write per interior cell that is not
// fixed; a fixed cell is left as it is after its center read.
// One item is at work at a time: req_ready is low while an item is at work or
// while a response waits.
// A response holds on rsp_ until rsp_ready; the next item is taken after that.
// Reset clears control state and config to 64x64 with zero coefficients; the
// grid memory is not cleared and holds garbage until written.
module heat_stencil_grid_sweep_unit #(
   parameter int MAX_ROWS = hsgs_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = hsgs_pkg::MAX_COLS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   hsgs_if.sink                     req,
   hsgs_if.source                   rsp,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [hsgs_pkg::CFG_W-1:0] csr_data
);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int AW = RW + CW;
   localparam int DEPTH = 1 << AW;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_FIX, S_C, S_N, S_S, S_W, S_E, S_MUL, S_ADD, S_NEXT, S_RSP
   } state_type;

   state_type   state_ff;
   logic [6:0]  rows_ff, cols_ff;
   logic signed [31:0] cx_ff, cy_ff;
   logic [RW-1:0] r_ff;
   logic [CW-1:0] c_ff;
   logic [RW-1:0] nr_m1;
   logic [CW-1:0] nc_m1;
   logic [10:0] nr, nc;
   logic signed [31:0] cv_ff, acc_ff;
   logic signed [33:0] dn_ff, dw_ff;
   logic        sat_ff;
   logic        upd_ff;
   hsgs_pkg::rsp_word_type rsp_ff;
   logic        rsp_v_ff;

   logic [31:0] mem_val [DEPTH];
   logic        mem_fix [DEPTH];
   logic [AW-1:0] raddr;
   logic [31:0] rdata_ff;
   logic        rfix_ff;
   logic        we;
   logic [AW-1:0] waddr;
   logic [31:0] wdata;
   logic        wfix;

   logic signed [31:0] mcoef;
   logic signed [33:0] mdiff;
   logic signed [49:0] term;
   logic signed [49:0] tx_ff;
   logic signed [50:0] sum;
   logic        in_grid;
   logic [RW-1:0] rq;
   logic [CW-1:0] cq;

   hsgs_term u_term (.clock(clock), .coef(mcoef), .diff(mdiff), .term(term));

   always_comb begin
      nr = (rows_ff < 7'd3) ? 11'd3 : ((11'(rows_ff) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS)
           : 11'(rows_ff));
      nc = (cols_ff < 7'd3) ? 11'd3 : ((11'(cols_ff) > 11'(MAX_COLS)) ? 11'(MAX_COLS)
           : 11'(cols_ff));
      nr_m1 = RW'(nr - 11'd1);
      nc_m1 = CW'(nc - 11'd1);
      in_grid = (11'(req.word.row) < nr) && (11'(req.word.col) < nc);
      rq = RW'(req.word.row);
      cq = CW'(req.word.col);
   end

   always_comb begin
      raddr = {r_ff, c_ff};
      case (state_ff)
         S_IDLE: raddr = {rq, cq};
         S_FIX:  raddr = {r_ff, c_ff};
         S_C:    raddr = {r_ff - RW'(1), c_ff};
         S_N:    raddr = {r_ff + RW'(1), c_ff};
         S_S:    raddr = {r_ff, c_ff - CW'(1)};
         S_W:    raddr = {r_ff, c_ff + CW'(1)};
         default: raddr = {r_ff, c_ff};
      endcase
   end

   always_comb begin
      mcoef = (state_ff == S_MUL) ? cy_ff : cx_ff;
      mdiff = (state_ff == S_MUL) ? dw_ff : dn_ff;
      sum = 51'(cv_ff) + 51'(tx_ff) + 51'(term);
      we = 1'b0;
      waddr = {r_ff, c_ff};
      wdata = acc_ff;
      wfix = 1'b0;
      if (state_ff == S_IDLE && req.valid && req.word.kind == hsgs_pkg::KIND_WRITE
          && in_grid) begin
         we = 1'b1;
         waddr = {rq, cq};
         wdata = req.word.cell_value;
         wfix = req.word.is_fixed;
      end else if (state_ff == S_NEXT && upd_ff) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem_val[raddr];
      rfix_ff <= mem_fix[raddr];
      if (we) begin
         mem_val[waddr] <= wdata;
         mem_fix[waddr] <= wfix;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.word  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= 7'd64;
         cols_ff <= 7'd64;
         cx_ff <= '0;
         cy_ff <= '0;
         rsp_v_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hsgs_pkg::REG_ROWS: rows_ff <= csr_data[6:0];
               hsgs_pkg::REG_COLS: cols_ff <= csr_data[6:0];
               hsgs_pkg::REG_CX:   cx_ff <= csr_data;
               hsgs_pkg::REG_CY:   cy_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  case (req.word.kind)
                     hsgs_pkg::KIND_SWEEP: begin
                        r_ff <= RW'(1);
                        c_ff <= CW'(1);
                        sat_ff <= 1'b0;
                        state_ff <= S_FIX;
                     end
                     hsgs_pkg::KIND_READ: begin
                        rsp_ff.read_value <= '0;
                        if (in_grid) state_ff <= S_RD;
                        else state_ff <= S_RSP;
                        rsp_ff.sweep_done <= 1'b0;
                        rsp_ff.saturated <= 1'b0;
                        rsp_v_ff <= !in_grid;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD: begin
               rsp_ff.read_value <= rdata_ff;
               rsp_v_ff <= 1'b1;
               state_ff <= S_RSP;
            end
            S_FIX: state_ff <= S_C;
            S_C: begin
               if (rfix_ff) begin
                  upd_ff <= 1'b0;
                  state_ff <= S_NEXT;
               end else begin
                  cv_ff <= rdata_ff;
                  state_ff <= S_N;
               end
            end
            S_N: begin
               dn_ff <= 34'(signed'(rdata_ff)) - 34'(cv_ff) - 34'(cv_ff);
               state_ff <= S_S;
            end
            S_S: begin
               dn_ff <= dn_ff + 34'(signed'(rdata_ff));
               dw_ff <= -34'(cv_ff) - 34'(cv_ff);
               state_ff <= S_W;
            end
            S_W: begin
               dw_ff <= dw_ff + 34'(signed'(rdata_ff));
               state_ff <= S_E;
            end
            S_E: begin
               dw_ff <= dw_ff + 34'(signed'(rdata_ff));
               state_ff <= S_MUL;
            end
            S_MUL: begin
               tx_ff <= term;
               state_ff <= S_ADD;
            end
            S_ADD: begin
               if (sum > 51'sd2147483647) begin
                  acc_ff <= 32'h7fffffff;
                  sat_ff <= 1'b1;
               end else if (sum < -51'sd2147483648) begin
                  acc_ff <= 32'h80000000;
                  sat_ff <= 1'b1;
               end else acc_ff <= 32'(sum);
               upd_ff <= 1'b1;
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (c_ff + CW'(1) < nc_m1) begin
                  c_ff <= c_ff + CW'(1);
                  state_ff <= S_FIX;
               end else if (r_ff + RW'(1) < nr_m1) begin
                  c_ff <= CW'(1);
                  r_ff <= r_ff + RW'(1);
                  state_ff <= S_FIX;
               end else begin
                  rsp_ff.read_value <= '0;
                  rsp_ff.sweep_done <= 1'b1;
                  rsp_ff.saturated <= sat_ff;
                  rsp_v_ff <= 1'b1;
                  state_ff <= S_RSP;
               end
            end
            S_RSP: begin
               if (rsp.ready) begin
                  rsp_v_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("ready while response pending");
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> state_ff == S_RSP) else $error("response outside response state");
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.word.sweep_done) |-> rsp.word.read_value == '0)
      else $error("sweep response carries value");
   a_sat_only_sweep: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.word.saturated) |-> rsp.word.sweep_done)
      else $error("saturated without sweep");
`endif
endmodule

// ----- bench/heat_stencil_grid_sweep_unit_tb.sv -----
// testbench: heat stencil sweep unit checked against a grid predictor, directed and random traffic
`timescale 1ns / 1ps

class grid_scoreboard;
   logic [31:0]    cells [4096];
   bit             fixed [4096];
   bit             written [4096];
   logic [6:0]     rows_reg;
   logic [6:0]     cols_reg;
   logic [31:0]    cx_reg;
   logic [31:0]    cy_reg;
   hsgs_pkg::rsp_word_type expected_words [$];
   int             errors;

   function new();
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      cx_reg = '0;
      cy_reg = '0;
      errors = 0;
      foreach (written[i]) written[i] = 0;
   endfunction

   function int eff_rows();
      return (rows_reg < 3) ? 3 : (rows_reg > 64) ? 64 : int'(rows_reg);
   endfunction

   function int eff_cols();
      return (cols_reg < 3) ? 3 : (cols_reg > 64) ? 64 : int'(cols_reg);
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
         hsgs_pkg::REG_ROWS: rows_reg = data[6:0];
         hsgs_pkg::REG_COLS: cols_reg = data[6:0];
         hsgs_pkg::REG_CX:   cx_reg = data;
         hsgs_pkg::REG_CY:   cy_reg = data;
         default: ;
      endcase
   endfunction

   function longint scaled_term(longint k, longint d);
      bit neg;
      longint unsigned mk, md, mag;
      neg = (k < 0) != (d < 0);
      mk = (k < 0) ? -k : k;
      md = (d < 0) ? -d : d;
      mag = ((mk * md) + 64'h8000) >> 16;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function bit sweep_grid();
      int nr, nc, at;
      longint cv, dn, dw, sum, kx, ky;
      bit clipped;
      nr = eff_rows();
      nc = eff_cols();
      kx = longint'($signed(cx_reg));
      ky = longint'($signed(cy_reg));
      clipped = 0;
      for (int r = 1; r + 1 < nr; r++) begin
         for (int c = 1; c + 1 < nc; c++) begin
            at = r * 64 + c;
            if (fixed[at]) continue;
            cv = longint'($signed(cells[at]));
            dn = longint'($signed(cells[at - 64])) + longint'($signed(cells[at + 64])) - 2 * cv;
            dw = longint'($signed(cells[at - 1])) + longint'($signed(cells[at + 1])) - 2 * cv;
            sum = cv + scaled_term(kx, dn) + scaled_term(ky, dw);
            if (sum > 64'sd2147483647) begin
               sum = 64'sd2147483647;
               clipped = 1;
            end
            if (sum < -64'sd2147483648) begin
               sum = -64'sd2147483648;
               clipped = 1;
            end
            cells[at] = sum[31:0];
         end
      end
      return clipped;
   endfunction

   function void note_req(hsgs_pkg::req_word_type w);
      bit in_grid;
      int at;
      hsgs_pkg::rsp_word_type e;
      in_grid = (int'(w.row) < eff_rows()) && (int'(w.col) < eff_cols());
      at = int'(w.row) * 64 + int'(w.col);
      e = '0;
      case (w.kind)
         hsgs_pkg::KIND_WRITE: begin
            if (in_grid) begin
               cells[at] = w.cell_value;
               fixed[at] = w.is_fixed;
               written[at] = 1;
            end
         end
         hsgs_pkg::KIND_SWEEP: begin
            e.sweep_done = 1'b1;
            e.saturated = sweep_grid();
            expected_words.push_back(e);
         end
         hsgs_pkg::KIND_READ: begin
            e.read_value = in_grid ? cells[at] : '0;
            expected_words.push_back(e);
         end
         default: ;
      endcase
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %h expected %h", what, got, exp);
      errors++;
   endtask

   task check_rsp(hsgs_pkg::rsp_word_type w);
      hsgs_pkg::rsp_word_type e;
      if (expected_words.size() == 0) begin
         report("unexpected word", {w.read_value}, '0);
      end else begin
         e = expected_words.pop_front();
         if (w.read_value !== e.read_value) report("read_value", w.read_value, e.read_value);
         if (w.sweep_done !== e.sweep_done) report("sweep_done", w.sweep_done, e.sweep_done);
         if (w.saturated !== e.saturated) report("saturated", w.saturated, e.saturated);
      end
   endtask
endclass

module heat_stencil_grid_sweep_unit_tb;
   logic              clock = 0;
   logic              reset = 1;
   logic              csr_we = 0;
   logic [1:0]        csr_index = '0;
   logic [hsgs_pkg::CFG_W-1:0] csr_data = '0;
   int                burst_left = 0;
   int                hold_asked = 0;
   int                hold_seen = 0;
   grid_scoreboard    sb;

   hsgs_if #(.word_type(hsgs_pkg::req_word_type)) req_ch ();
   hsgs_if #(.word_type(hsgs_pkg::rsp_word_type)) rsp_ch ();

   heat_stencil_grid_sweep_unit u_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // receiver stall pattern, plus long hold-offs on request
   initial begin
      int mode, left, hold;
      rsp_ch.ready = 0;
      mode = 0;
      left = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold = 400;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(8, 80);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_ch.ready = 0;
         end else begin
            case (mode)
               0: rsp_ch.ready = 1;
               1: rsp_ch.ready = 1'($urandom_range(0, 1));
               2: rsp_ch.ready = ($urandom_range(0, 7) != 0);
               default: rsp_ch.ready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_rsp(rsp_ch.word);
   end

   // called just after a falling edge, returns just after a falling edge
   task send_word(hsgs_pkg::req_word_type w);
      req_ch.word = w;
      req_ch.valid = 1;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_req(w);
      @(negedge clock);
      if (burst_left == 0) begin
         req_ch.valid = 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task wait_drained();
      req_ch.valid = 0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task write_reg(logic [1:0] idx, logic [31:0] data);
      wait_drained();
      csr_we = 1;
      csr_index = idx;
      csr_data = data;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_we = 0;
   endtask

   function logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return $urandom_range(0, 32'h200000) - 32'h100000;
      endcase
   endfunction

   function hsgs_pkg::req_word_type make_word(logic [1:0] kind, int r, int c,
                                              logic [31:0] v, bit f);
      hsgs_pkg::req_word_type w;
      w.kind = kind;
      w.row = r[5:0];
      w.col = c[5:0];
      w.cell_value = v;
      w.is_fixed = f;
      return w;
   endfunction

   task fill_grid();
      int nr, nc;
      bit edge_cell;
      nr = sb.eff_rows();
      nc = sb.eff_cols();
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (!sb.written[r * 64 + c]) begin
               edge_cell = (r == 0) || (c == 0) || (r == nr - 1) || (c == nc - 1);
               send_word(make_word(hsgs_pkg::KIND_WRITE, r, c, pick_value(),
                                   edge_cell ? ($urandom_range(0, 3) != 0)
                                             : ($urandom_range(0, 7) == 0)));
            end
   endtask

   task sweep_once();
      fill_grid();
      send_word(make_word(hsgs_pkg::KIND_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63),
                          $urandom, 1'($urandom_range(0, 1))));
   endtask

   task random_item(bit sweeps_ok);
      int r, c, pick;
      logic [31:0] junk;
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      junk = $urandom;
      if ($urandom_range(0, 1)) begin
         r = r % sb.eff_rows();
         c = c % sb.eff_cols();
      end
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
         send_word(make_word(hsgs_pkg::KIND_WRITE, r, c, pick_value(),
                             $urandom_range(0, 3) == 0));
      end else if (pick < 16) begin
         if (r < sb.eff_rows() && c < sb.eff_cols() && !sb.written[r * 64 + c])
            send_word(make_word(hsgs_pkg::KIND_WRITE, r, c, pick_value(),
                                1'($urandom_range(0, 1))));
         else
            send_word(make_word(hsgs_pkg::KIND_READ, r, c, junk, 1'($urandom_range(0, 1))));
      end else if (pick < 19 && sweeps_ok) begin
         sweep_once();
      end else begin
         send_word(make_word(hsgs_pkg::KIND_UNUSED, r, c, junk, 1'($urandom_range(0, 1))));
      end
   endtask

   function logic [31:0] pick_coef();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         3: return '0;
         default: return -$urandom_range(1000, 16384);
      endcase
   endfunction

   initial begin
      int nr, nc;
      bit big;
      sb = new();
      req_ch.valid = 0;
      req_ch.word = '0;
      repeat (5) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // directed: smallest grid, extremes, saturation, ignored items
      write_reg(hsgs_pkg::REG_ROWS, {25'h1ffffff, 7'd3});
      write_reg(hsgs_pkg::REG_COLS, 32'd3);
      write_reg(hsgs_pkg::REG_CX, 32'h7fffffff);
      write_reg(hsgs_pkg::REG_CY, 32'h7fffffff);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            send_word(make_word(hsgs_pkg::KIND_WRITE, r, c,
                                (r == 1 && c == 1) ? 32'h80000000 : 32'h7fffffff,
                                !(r == 1 && c == 1)));
      send_word(make_word(hsgs_pkg::KIND_WRITE, 5, 1, 32'h12345678, 1'b1));
      send_word(make_word(hsgs_pkg::KIND_WRITE, 63, 63, 32'hffffffff, 1'b0));
      send_word(make_word(hsgs_pkg::KIND_UNUSED, 1, 1, 32'hffffffff, 1'b1));
      send_word(make_word(hsgs_pkg::KIND_SWEEP, 0, 0, 32'd0, 1'b0));
      send_word(make_word(hsgs_pkg::KIND_READ, 1, 1, 32'd0, 1'b0));
      send_word(make_word(hsgs_pkg::KIND_READ, 0, 0, 32'hffffffff, 1'b1));
      send_word(make_word(hsgs_pkg::KIND_READ, 63, 63, 32'd0, 1'b0));
      send_word(make_word(hsgs_pkg::KIND_READ, 2, 5, 32'd0, 1'b0));
      write_reg(hsgs_pkg::REG_CX, 32'h80000000);
      write_reg(hsgs_pkg::REG_CY, 32'h80000000);
      send_word(make_word(hsgs_pkg::KIND_SWEEP, 63, 63, 32'hffffffff, 1'b1));
      send_word(make_word(hsgs_pkg::KIND_READ, 1, 1, 32'd0, 1'b0));
      write_reg(hsgs_pkg::REG_CX, -32'sd16384);
      write_reg(hsgs_pkg::REG_CY, 32'd0);
      send_word(make_word(hsgs_pkg::KIND_SWEEP, 0, 0, 32'd0, 1'b0));
      send_word(make_word(hsgs_pkg::KIND_READ, 1, 1, 32'd0, 1'b0));

      // long receiver hold-off while reads keep coming
      hold_asked++;
      for (int i = 0; i < 8; i++)
         send_word(make_word(hsgs_pkg::KIND_READ, i % 3, 2, 32'd0, 1'b0));

      // random phases over several grid sizes and coefficients
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            2: begin nr = 0; nc = 127; end
            5: begin nr = 64; nc = 64; end
            6: begin nr = 127; nc = 4; end
            default: begin nr = $urandom_range(3, 9); nc = $urandom_range(3, 9); end
         endcase
         big = (phase == 2) || (phase == 5) || (phase == 6);
         write_reg(hsgs_pkg::REG_ROWS, {25'($urandom), 7'(nr)});
         write_reg(hsgs_pkg::REG_COLS, {25'($urandom), 7'(nc)});
         write_reg(hsgs_pkg::REG_CX, pick_coef());
         write_reg(hsgs_pkg::REG_CY, pick_coef());
         for (int i = 0; i < 6; i++) random_item(!big);
         if (!big) begin
            sweep_once();
            send_word(make_word(hsgs_pkg::KIND_READ, 1, 1, 32'd0, 1'b0));
         end
      end

      wait_drained();
      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
